>>> design/adt_pkg.sv
// Shared types, codes and sizes of the aging device table.
package adt_pkg;

    // Table size and the index and count widths that follow from it.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the item ports.
    localparam int ADDR_W   = 48;
    localparam int TIME_W   = 32;
    localparam int RIDX_W   = 6;
    localparam int FCNT_W   = 7;
    localparam int WIDE_W   = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    // Timeout after reset, in milliseconds.
    localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT = TIME_W'(30000);

    typedef enum logic [1:0] {
        ACT_OBSERVE = 2'd0,
        ACT_SWEEP   = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STAT_UPDATED      = 3'd0,
        STAT_INSERTED     = 3'd1,
        STAT_FULL_DROPPED = 3'd2,
        STAT_IGNORED      = 3'd3,
        STAT_SWEPT        = 3'd4,
        STAT_CLEARED      = 3'd5,
        STAT_READ_OK      = 3'd6,
        STAT_READ_INVALID = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    // One table entry as stored in the slot memory.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [1:0]        address_type;
        logic signed [7:0] signal_strength;
        logic [3:0]        pattern;
        logic [TIME_W-1:0] seen_ms;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Access to the slot memory from the sequencer.
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        slot_t            wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } ram_req_t;

    // Verdict of the compare unit on one entry.
    typedef struct packed {
        logic match;
        logic expired;
    } cmp_res_t;

    // One finished result.
    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] removed_count;
        slot_t            entry;
    } res_t;

endpackage

>>> design/aging_device_table.sv
// Aging device table: an ordered table of up to 64 flagged devices keyed by a
// 48-bit address, held in one slot memory with a single read and a single
// write port. Observe and sweep walk the valid entries one per cycle through
// that read port and a shared compare unit; an observe that hits stops
// early. Clear, read and an observe with a zero pattern skip the scan.
// Input stall stays high while an item is in progress; a finished result
// waits in the output register, and the next item is accepted meanwhile.
// The timeout register may be written only while the block is idle.
module aging_device_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [adt_pkg::TIME_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [adt_pkg::ADDR_W-1:0]    address,
    input  logic [1:0]                    address_type,
    input  logic signed [7:0]             signal_strength,
    input  logic [3:0]                    pattern_index,
    input  logic [adt_pkg::TIME_W-1:0]    now_ms,
    input  logic [adt_pkg::RIDX_W-1:0]    read_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [adt_pkg::FCNT_W-1:0]    entry_count,
    output logic [adt_pkg::FCNT_W-1:0]    removed_count,
    output logic [adt_pkg::ADDR_W-1:0]    entry_address,
    output logic [1:0]                    entry_address_type,
    output logic signed [7:0]             entry_signal_strength,
    output logic [3:0]                    entry_pattern,
    output logic [adt_pkg::TIME_W-1:0]    entry_seen_ms
);

    import adt_pkg::*;

    logic [TIME_W-1:0] timeout_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic              out_free;
    logic              res_valid;
    res_t              res;
    ram_req_t          ram_req;
    logic [SLOT_W-1:0] ram_rdata;

    // Timeout register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= DEFAULT_TIMEOUT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // Slot memory.
    adt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rdata)
    );

    // Sequencer.
    adt_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .address         (address),
        .address_type    (address_type),
        .signal_strength (signal_strength),
        .pattern_index   (pattern_index),
        .now_ms          (now_ms),
        .read_index      (read_index),
        .timeout_ms      (timeout_reg),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res             (res),
        .ram_req         (ram_req),
        .ram_rdata       (slot_t'(ram_rdata))
    );

    // Output register; it frees up in the cycle its transaction completes.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid             = out_valid_reg;
    assign status                = out_res_reg.status;
    assign entry_count           = FCNT_W'(out_res_reg.entry_count);
    assign removed_count         = FCNT_W'(out_res_reg.removed_count);
    assign entry_address         = out_res_reg.entry.address;
    assign entry_address_type    = out_res_reg.entry.address_type;
    assign entry_signal_strength = out_res_reg.entry.signal_strength;
    assign entry_pattern         = out_res_reg.entry.pattern;
    assign entry_seen_ms         = out_res_reg.entry.seen_ms;

    // A new result never overwrites one that is still stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result loaded over a stalled transaction");

    // The table never reports more entries than it can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= FCNT_W'(CAPACITY)))
        else $error("entry count beyond capacity");

    // Entry fields are zero unless a read found its entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STAT_READ_OK)) |->
        ((entry_address == '0) && (entry_seen_ms == '0) && (entry_pattern == '0)))
        else $error("entry fields set outside a successful read");

    // Only a sweep reports removed entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STAT_SWEPT)) |-> (removed_count == '0))
        else $error("removed count outside a sweep");

endmodule

>>> design/adt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module adt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/adt_cmp.sv
// Shared compare unit: address match and wrapped age against the timeout.
module adt_cmp (
    input  adt_pkg::slot_t                 entry,
    input  logic [adt_pkg::ADDR_W-1:0]     key_address,
    input  logic [adt_pkg::TIME_W-1:0]     now_ms,
    input  logic [adt_pkg::TIME_W-1:0]     timeout_ms,
    output adt_pkg::cmp_res_t              result
);

    import adt_pkg::*;

    logic [TIME_W-1:0] age;

    // Age wraps modulo 2^32, so a plain subtract is exact.
    assign age            = now_ms - entry.seen_ms;
    assign result.match   = (entry.address == key_address);
    assign result.expired = (age > timeout_ms);

endmodule

>>> design/adt_ctrl.sv
// Sequencer that walks the slot memory one entry per cycle for observe and sweep.
module adt_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [adt_pkg::ADDR_W-1:0]    address,
    input  logic [1:0]                    address_type,
    input  logic signed [7:0]             signal_strength,
    input  logic [3:0]                    pattern_index,
    input  logic [adt_pkg::TIME_W-1:0]    now_ms,
    input  logic [adt_pkg::RIDX_W-1:0]    read_index,
    input  logic [adt_pkg::TIME_W-1:0]    timeout_ms,
    input  logic                          out_free,
    output logic                          res_valid,
    output adt_pkg::res_t                 res,
    output adt_pkg::ram_req_t             ram_req,
    input  adt_pkg::slot_t                ram_rdata
);

    import adt_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]  keep_reg, keep_next;
    logic [CNT_W-1:0]  removed_reg, removed_next;
    status_t           status_reg, status_next;
    slot_t             entry_reg, entry_next;

    action_t           action_reg, action_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [1:0]        atype_reg, atype_next;
    logic signed [7:0] rssi_reg, rssi_next;
    logic [3:0]        pat_reg, pat_next;
    logic [TIME_W-1:0] now_reg, now_next;

    action_t           in_action;
    logic              ridx_ok;
    logic              issue;
    logic              scan_hit;
    slot_t             upd_slot;
    slot_t             new_slot;
    cmp_res_t          cmp;

    // Shared compare unit, fed with the entry read in the previous cycle.
    adt_cmp u_cmp (
        .entry       (ram_rdata),
        .key_address (addr_reg),
        .now_ms      (now_reg),
        .timeout_ms  (timeout_ms),
        .result      (cmp)
    );

    // Decode of the incoming item and of the scan position.
    assign in_action = action_t'(action);
    assign ridx_ok   = (WIDE_W'(read_index) < WIDE_W'(count_reg));
    assign issue     = (rd_idx_reg < count_reg);
    assign scan_hit  = cmp_valid_reg && (action_reg == ACT_OBSERVE) && cmp.match;
    assign in_stall  = (state_reg != ST_IDLE);

    // Refreshed entry keeps its address type and pattern.
    always_comb
    begin
        upd_slot                 = ram_rdata;
        upd_slot.signal_strength = rssi_reg;
        upd_slot.seen_ms         = now_reg;
    end

    assign new_slot = '{address: addr_reg, address_type: atype_reg,
                        signal_strength: rssi_reg, pattern: pat_reg,
                        seen_ms: now_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_action)
                        ACT_OBSERVE:
                            state_next = (pattern_index == 4'd0) ? ST_DONE : ST_SCAN;
                        ACT_SWEEP:
                            state_next = ST_SCAN;
                        ACT_CLEAR:
                            state_next = ST_DONE;
                        ACT_READ:
                            state_next = ridx_ok ? ST_RDWAIT : ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || (!cmp_valid_reg && !issue))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RDWAIT:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath, memory access and result.
    always_comb
    begin
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        keep_next      = keep_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        entry_next     = entry_reg;
        action_next    = action_reg;
        addr_next      = addr_reg;
        atype_next     = atype_reg;
        rssi_next      = rssi_reg;
        pat_next       = pat_reg;
        now_next       = now_reg;
        ram_req        = '0;
        res_valid      = 1'b0;
        res            = '{status: status_reg, entry_count: count_reg,
                           removed_count: removed_reg, entry: entry_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next    = in_action;
                    addr_next      = address;
                    atype_next     = address_type;
                    rssi_next      = signal_strength;
                    pat_next       = pattern_index;
                    now_next       = now_ms;
                    rd_idx_next    = '0;
                    cmp_valid_next = 1'b0;
                    keep_next      = '0;
                    removed_next   = '0;
                    entry_next     = '0;
                    unique case (in_action)
                        ACT_OBSERVE:
                            status_next = STAT_IGNORED;
                        ACT_SWEEP:
                            status_next = STAT_SWEPT;
                        ACT_CLEAR:
                        begin
                            count_next  = '0;
                            status_next = STAT_CLEARED;
                        end
                        ACT_READ:
                        begin
                            status_next     = STAT_READ_INVALID;
                            ram_req.rd_en   = ridx_ok;
                            ram_req.rd_addr = IDX_W'(read_index);
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue the next read while the previous entry is compared.
                ram_req.rd_en   = issue;
                ram_req.rd_addr = rd_idx_reg[IDX_W-1:0];
                cmp_valid_next  = issue;
                cmp_idx_next    = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = CNT_W'(rd_idx_reg + 1'b1);
                end

                if (cmp_valid_reg)
                begin
                    if (action_reg == ACT_OBSERVE)
                    begin
                        if (cmp.match)
                        begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_addr = cmp_idx_reg;
                            ram_req.wr_data = upd_slot;
                            status_next     = STAT_UPDATED;
                        end
                    end
                    else if (cmp.expired)
                    begin
                        removed_next = CNT_W'(removed_reg + 1'b1);
                    end
                    else
                    begin
                        // Survivor moves down to close any gap.
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = keep_reg[IDX_W-1:0];
                        ram_req.wr_data = ram_rdata;
                        keep_next       = CNT_W'(keep_reg + 1'b1);
                    end
                end
                else if (!issue)
                begin
                    // Scan finished with nothing in flight.
                    if (action_reg == ACT_OBSERVE)
                    begin
                        if (count_reg < CNT_W'(CAPACITY))
                        begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_addr = count_reg[IDX_W-1:0];
                            ram_req.wr_data = new_slot;
                            count_next      = CNT_W'(count_reg + 1'b1);
                            status_next     = STAT_INSERTED;
                        end
                        else
                        begin
                            status_next = STAT_FULL_DROPPED;
                        end
                    end
                    else
                    begin
                        count_next  = keep_reg;
                        status_next = STAT_SWEPT;
                    end
                end
            end
            ST_RDWAIT:
            begin
                entry_next  = ram_rdata;
                status_next = STAT_READ_OK;
            end
            ST_DONE:
                res_valid = out_free;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            keep_reg      <= '0;
            removed_reg   <= '0;
            action_reg    <= ACT_OBSERVE;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            keep_reg      <= keep_next;
            removed_reg   <= removed_next;
            action_reg    <= action_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        entry_reg   <= entry_next;
        addr_reg    <= addr_next;
        atype_reg   <= atype_next;
        rssi_reg    <= rssi_next;
        pat_reg     <= pat_next;
        now_reg     <= now_next;
    end

endmodule
